FILE: hdl/salts_pkg.sv
// Package for the set-associative LRU tag store: sizes, action codes,
// item and row types, and the reset contents of one set row.
// No dependencies.
package salts_pkg;

    localparam int SETS       = 64;
    localparam int WAYS       = 8;
    localparam int LINE_BYTES = 64;
    localparam int ADDR_BITS  = 32;

    localparam int ADDR_W = 32;
    localparam int TAG_W  = 20;
    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W = WAY_W;

    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ?
        {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FETCH = 2'd2;
    localparam logic [1:0] ACT_WBACK = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [1:0]        action;
        logic              is_fill;
    } t_in_item;

    typedef struct packed {
        logic             hit;
        logic             victim_dirty;
        logic [TAG_W-1:0] victim_tag;
        logic             bad_request;
    } t_out_item;

    typedef struct packed {
        logic              valid;
        logic              dirty;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    // Row after reset: all invalid and clean, rank equal to way index.
    function automatic t_row row_reset();
        t_row row;
        for (int w = 0; w < WAYS; w++) begin
            row[w].valid = 1'b0;
            row[w].dirty = 1'b0;
            row[w].tag   = '0;
            row[w].rank  = RANK_W'(w);
        end
        return row;
    endfunction

endpackage

FILE: hdl/set_assoc_lru_tag_store.sv
// Set-associative write-back cache tag store with true LRU replacement.
// One memory row per set holds valid, dirty, tag and rank of every way.
// Depends on salts_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// On accept the set row is read from the synchronous set memory; in the
// lookup state, with the output register free, the updated row is written back
// and the result registered. The single read/write port of that memory sets
// the rate. Reset clears a per-set init bit in flops; a set never written
// reads as its reset contents, so no clearing pass is needed. A stalled
// result holds in the output register while the next item is accepted;
// the item then waits in the lookup state until the output register frees up.
module set_assoc_lru_tag_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  salts_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output salts_pkg::t_out_item o_out_item
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    // control
    logic r_state, n_state;
    logic r_out_valid;
    logic [salts_pkg::SETS-1:0] r_row_init;

    // item being worked on and its set row
    salts_pkg::t_in_item  r_item;
    salts_pkg::t_row      r_rd_row;
    logic                 r_rd_init;
    salts_pkg::t_out_item r_out;

    // set memory
    salts_pkg::t_row r_mem [salts_pkg::SETS];

    logic                           in_acc;
    logic                           out_free;
    logic                           mem_we;
    logic [salts_pkg::SET_W-1:0]    in_set;
    logic [salts_pkg::SET_W-1:0]    cur_set;
    logic [salts_pkg::TAG_W-1:0]    cur_tag;
    logic [salts_pkg::ADDR_W-1:0]   in_addr_cut;
    logic [salts_pkg::ADDR_W-1:0]   cur_addr_cut;
    salts_pkg::t_row                cur_row;
    salts_pkg::t_row                new_row;
    salts_pkg::t_out_item           result;

    logic                           hit;
    logic [salts_pkg::WAY_W-1:0]    hit_way;
    logic                           any_inv;
    logic [salts_pkg::WAY_W-1:0]    inv_way;
    logic [salts_pkg::WAY_W-1:0]    lru_way;
    logic                           touch;
    logic [salts_pkg::WAY_W-1:0]    touch_way;
    logic [salts_pkg::RANK_W-1:0]   old_rank;
    logic [salts_pkg::WAYS-1:0]     rank0_vec;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign mem_we      = (r_state == S_LOOK) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // address split
    assign in_addr_cut  = i_in_item.address & salts_pkg::ADDR_MASK;
    assign cur_addr_cut = r_item.address & salts_pkg::ADDR_MASK;
    assign in_set  = salts_pkg::SET_W'(in_addr_cut >> salts_pkg::OFF_W);
    assign cur_set = salts_pkg::SET_W'(cur_addr_cut >> salts_pkg::OFF_W);
    assign cur_tag = salts_pkg::TAG_W'(cur_addr_cut >>
                                       (salts_pkg::OFF_W + salts_pkg::SET_W));

    // lookup, victim choice and row update
    always_comb begin
        cur_row = r_rd_init ? r_rd_row : salts_pkg::row_reset();

        hit     = 1'b0;
        hit_way = '0;
        any_inv = 1'b0;
        inv_way = '0;
        for (int w = salts_pkg::WAYS - 1; w >= 0; w--) begin
            if (cur_row[w].valid && (cur_row[w].tag == cur_tag)) begin
                hit     = 1'b1;
                hit_way = salts_pkg::WAY_W'(w);
            end
            if (!cur_row[w].valid) begin
                any_inv = 1'b1;
                inv_way = salts_pkg::WAY_W'(w);
            end
        end

        // ranks are a permutation: the LRU way holds the top rank
        lru_way = '0;
        for (int w = 0; w < salts_pkg::WAYS; w++) begin
            if (cur_row[w].rank == salts_pkg::RANK_W'(salts_pkg::WAYS - 1)) begin
                lru_way = salts_pkg::WAY_W'(w);
            end
        end

        new_row             = cur_row;
        result.hit          = hit;
        result.victim_dirty = 1'b0;
        result.victim_tag   = '0;
        result.bad_request  = 1'b0;
        touch               = 1'b0;
        touch_way           = hit_way;

        if (!r_item.is_fill) begin
            if (r_item.action == salts_pkg::ACT_WBACK) begin
                result.bad_request = 1'b1;
            end else if (hit) begin
                if (r_item.action == salts_pkg::ACT_WRITE) begin
                    new_row[hit_way].dirty = 1'b1;
                end
                touch = 1'b1;
            end
        end else if (r_item.action == salts_pkg::ACT_WBACK) begin
            if (hit) begin
                new_row[hit_way].dirty = 1'b1;
            end else begin
                result.bad_request = 1'b1;
            end
        end else if (hit) begin
            result.bad_request = 1'b1;
        end else begin
            touch_way = any_inv ? inv_way : lru_way;
            if (!any_inv && cur_row[lru_way].dirty) begin
                result.victim_dirty = 1'b1;
                result.victim_tag   = cur_row[lru_way].tag;
            end
            new_row[touch_way].valid = 1'b1;
            new_row[touch_way].dirty = (r_item.action == salts_pkg::ACT_WRITE);
            new_row[touch_way].tag   = cur_tag;
            touch = 1'b1;
        end

        // move to most recent
        old_rank = cur_row[touch_way].rank;
        if (touch) begin
            for (int w = 0; w < salts_pkg::WAYS; w++) begin
                if (cur_row[w].rank < old_rank) begin
                    new_row[w].rank = cur_row[w].rank + salts_pkg::RANK_W'(1);
                end
            end
            new_row[touch_way].rank = '0;
        end

        for (int w = 0; w < salts_pkg::WAYS; w++) begin
            rank0_vec[w] = (new_row[w].rank == '0);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_LOOK;
            end
            S_LOOK: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row_init  <= '0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_out_valid         <= 1'b1;
                r_row_init[cur_set] <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item    <= i_in_item;
            r_rd_init <= r_row_init[in_set];
        end
        if (mem_we) begin
            r_out <= result;
        end
    end

    // set memory: one read port on accept, one write port on write-back
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_row <= r_mem[in_set];
        end
        if (mem_we) begin
            r_mem[cur_set] <= new_row;
        end
    end

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_LOOK))
        else $error("accepted item did not enter lookup");

    a_write_in_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_LOOK) && !in_acc)
        else $error("set memory written outside lookup");

    a_rank_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> $onehot(rank0_vec))
        else $error("updated row lost its most recent way");

    a_victim_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.victim_dirty) |-> (o_out_item.victim_tag == '0))
        else $error("victim tag without dirty victim");

    a_bad_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.bad_request) |-> !o_out_item.victim_dirty)
        else $error("bad request reported an eviction");

endmodule
